/* hw/rtl/aosc_pkg.sv */
// Package for the additive oscillator: widths, register indexes, reset values,
// sine polynomial constants and the divider request and response types.
// No dependencies; the multiplier, the divider and the top import it.
package aosc_pkg;

  // Harmonic limit and sine resolution.
  localparam int MAX_HARMONICS   = 8;
  localparam int SINE_TABLE_BITS = 10;
  localparam logic [15:0] SINE_MASK = 16'(16'hFFFF << (16 - SINE_TABLE_BITS));

  // Sine polynomial constants, all Q-scaled as in the fixed-point evaluation.
  localparam logic [14:0] SIN_C1      = 15'd1193;
  localparam logic [14:0] SIN_C2      = 15'd10538;
  localparam logic [14:0] SIN_C3      = 15'd25729;
  localparam logic [14:0] SIN_MAG_MAX = 15'h7FFF;
  localparam logic [14:0] QUARTER     = 15'd16384;

  // Shared multiplier: unsigned 30 x 15 bits.
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 15;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Serial divider for the harmonic scaling by 1/k.
  localparam int DIV_W     = 38;
  localparam int DIV_D_W   = 4;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Harmonic counter and accumulators.
  localparam int HC_W       = 4;
  localparam int HK_W       = $clog2(MAX_HARMONICS + 2);
  localparam int LIM_W      = 35;
  localparam int SUM_W      = 41;
  localparam int FRAC_SHIFT = 22;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_FREQ_STEP        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VIB_ENABLE       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VIB_DEPTH_STEP   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_VIB_RATE_STEP    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HARMONIC_COUNT   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HARMONIC_WEIGHTS = 3'd6;

  localparam logic [30:0] FREQ_STEP_RESET = 31'd39370534;
  localparam logic [14:0] AMPLITUDE_RESET = 15'd3277;

  // Divider handshake between the sequencer and the divider.
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* hw/rtl/aosc_in_if.sv */
// Input channel of the additive oscillator: one beat per sample tick.
// Depends on nothing.
interface aosc_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

/* hw/rtl/aosc_out_if.sv */
// Output channel of the additive oscillator: one beat per audio sample.
// Depends on nothing.
interface aosc_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* hw/rtl/aosc_mul.sv */
// Shared multiplier of the oscillator: unsigned product with a registered output.
// Depends on aosc_pkg.
module aosc_mul (
  input  logic                         clk,
  input  logic [aosc_pkg::MUL_A_W-1:0] a,
  input  logic [aosc_pkg::MUL_B_W-1:0] b,
  output logic [aosc_pkg::MUL_P_W-1:0] p
);
  import aosc_pkg::*;

  // One product per cycle, available in the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

/* hw/rtl/aosc_div.sv */
// Restoring serial divider: one quotient bit a cycle, small unsigned divisor.
// Depends on aosc_pkg.
module aosc_div (
  input  logic               clk,
  input  logic               rst,
  input  aosc_pkg::div_req_t req,
  output aosc_pkg::div_rsp_t rsp
);
  import aosc_pkg::*;

  logic [DIV_W-1:0]     quo;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 fits;

  // Trial subtraction of the divisor from the partial remainder.
  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  // Iteration count and completion flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* hw/rtl/additive_oscillator_with_vibrato_top.sv */
// Additive oscillator with vibrato: fundamental plus up to eight harmonics, one sample a tick.
// Each harmonic costs a check, a 4-multiply sine, two more multiplies and a divide that runs 38
// iterations; vibrato, when on, adds a sine and a multiply for the fundamental's phase step.
// One tick is in flight at a time: a new tick is taken only after the previous sample is
// loaded into the output register. Synchronous reset loads the register defaults and clears
// all three phases.
module additive_oscillator_with_vibrato_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [aosc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [aosc_pkg::CFG_DATA_W-1:0]     cfg_data,
  aosc_in_if.sink                             tick,
  aosc_out_if.source                          audio
);
  import aosc_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_START   = 4'd1;
  localparam logic [3:0] ST_SIN0    = 4'd2;
  localparam logic [3:0] ST_SIN1    = 4'd3;
  localparam logic [3:0] ST_SIN2    = 4'd4;
  localparam logic [3:0] ST_SIN3    = 4'd5;
  localparam logic [3:0] ST_F_AMP   = 4'd6;
  localparam logic [3:0] ST_F_ACC   = 4'd7;
  localparam logic [3:0] ST_H_CHECK = 4'd8;
  localparam logic [3:0] ST_H_W     = 4'd9;
  localparam logic [3:0] ST_H_P     = 4'd10;
  localparam logic [3:0] ST_H_DIV   = 4'd11;
  localparam logic [3:0] ST_H_WAIT  = 4'd12;
  localparam logic [3:0] ST_V_MUL   = 4'd13;
  localparam logic [3:0] ST_V_ADD   = 4'd14;
  localparam logic [3:0] ST_DONE    = 4'd15;

  // Configuration registers.
  logic [30:0] freq_step;
  logic [14:0] amplitude;
  logic        vib_enable;
  logic [29:0] vib_depth_step;
  logic [30:0] vib_rate_step;
  logic [HC_W-1:0] harmonic_count;
  logic [63:0] harmonic_weights;

  // Oscillator state and sequencer.
  logic [31:0] fund_phase;
  logic [31:0] harm_phase;
  logic [31:0] vib_phase;
  logic [3:0]  state;
  logic [3:0]  ret_state;
  logic [HK_W-1:0] harm_k;
  logic        audio_valid;

  // Datapath registers.
  logic [14:0] sin_x;
  logic        sin_neg;
  logic [14:0] z2;
  logic [14:0] mag;
  logic        term_neg;
  logic [SUM_W-1:0] acc;
  logic [31:0] harm_ph;
  logic [LIM_W-1:0] harm_lim;
  logic [15:0] result;

  // Combinational signals.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic [15:0] sin_mt;
  logic [14:0] sin_mag;
  logic [HC_W-1:0] count_eff;
  logic [HK_W-1:0] k_m1;
  logic [7:0]  w_sel;
  logic        harm_go;
  logic [SUM_W-1:0] fund_term;
  logic [SUM_W-1:0] harm_term;
  logic [30:0] dev_mag;
  logic [31:0] vib_step;
  logic [SUM_W-FRAC_SHIFT-1:0] res;
  logic [15:0] res_sat;
  logic        out_load;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // Sine argument: quadrant sign and folded offset within the quarter wave.
  function automatic logic [15:0] sine_arg(input logic [31:0] ph);
    logic [15:0] u;
    logic [14:0] x;
    u = ph[31:16] & SINE_MASK;
    x = {1'b0, u[13:0]};
    if (u[14]) begin
      x = QUARTER - x;
    end
    return {u[15], x};
  endfunction

  aosc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  aosc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Register writes from the configuration port; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_step        <= FREQ_STEP_RESET;
      amplitude        <= AMPLITUDE_RESET;
      vib_enable       <= 1'b0;
      vib_depth_step   <= '0;
      vib_rate_step    <= '0;
      harmonic_count   <= '0;
      harmonic_weights <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FREQ_STEP:        freq_step        <= cfg_data[30:0];
        REG_AMPLITUDE:        amplitude        <= cfg_data[14:0];
        REG_VIB_ENABLE:       vib_enable       <= cfg_data[0];
        REG_VIB_DEPTH_STEP:   vib_depth_step   <= cfg_data[29:0];
        REG_VIB_RATE_STEP:    vib_rate_step    <= cfg_data[30:0];
        REG_HARMONIC_COUNT:   harmonic_count   <= cfg_data[HC_W-1:0];
        REG_HARMONIC_WEIGHTS: harmonic_weights <= cfg_data;
        default: ;
      endcase
    end
  end

  // Harmonic selection, sine magnitude and the arithmetic around the multiplier.
  always_comb begin
    count_eff = (harmonic_count > HC_W'(MAX_HARMONICS)) ? HC_W'(MAX_HARMONICS)
                                                        : harmonic_count;
    k_m1      = harm_k - 1'b1;
    w_sel     = 8'(harmonic_weights >> {k_m1, 3'b000});
    harm_go   = (harm_k != '0) && ((HC_W + HK_W)'(harm_k) <= (HC_W + HK_W)'(count_eff))
                && (harm_lim[LIM_W-1:31] == '0);
    sin_mt    = prod[28:13];
    sin_mag   = sin_mt[15] ? SIN_MAG_MAX : sin_mt[14:0];
    fund_term = SUM_W'(prod[29:0]) << 7;
    harm_term = SUM_W'(div_rsp.quotient);
    dev_mag   = term_neg ? 31'((prod + MUL_P_W'(32767)) >> 15) : 31'(prod >> 15);
    vib_step  = term_neg ? ({1'b0, freq_step} - {1'b0, dev_mag})
                         : ({1'b0, freq_step} + {1'b0, dev_mag});
    res       = acc[SUM_W-1:FRAC_SHIFT];
    if (res[SUM_W-FRAC_SHIFT-1:15] == '0 || res[SUM_W-FRAC_SHIFT-1:15] == '1) begin
      res_sat = res[15:0];
    end else begin
      res_sat = res[SUM_W-FRAC_SHIFT-1] ? 16'h8000 : 16'h7FFF;
    end
    out_load  = (state == ST_DONE) && (!audio_valid || audio.ready);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SIN0: begin
        mul_a = MUL_A_W'(sin_x);
        mul_b = sin_x;
      end
      ST_SIN1: begin
        mul_a = MUL_A_W'(SIN_C1);
        mul_b = prod[28:14];
      end
      ST_SIN2: begin
        mul_a = MUL_A_W'(SIN_C2 - prod[28:14]);
        mul_b = z2;
      end
      ST_SIN3: begin
        mul_a = MUL_A_W'(SIN_C3 - prod[28:14]);
        mul_b = sin_x;
      end
      ST_F_AMP: begin
        mul_a = MUL_A_W'(amplitude);
        mul_b = sin_mag;
      end
      ST_H_W: begin
        mul_a = MUL_A_W'(w_sel);
        mul_b = amplitude;
      end
      ST_H_P: begin
        mul_a = MUL_A_W'(prod[22:0]);
        mul_b = mag;
      end
      ST_V_MUL: begin
        mul_a = vib_depth_step;
        mul_b = sin_mag;
      end
      default: ;
    endcase
  end

  // Divider request for the harmonic scaling by 1/k.
  always_comb begin
    div_req.start    = (state == ST_H_DIV);
    div_req.dividend = prod[DIV_W-1:0];
    div_req.divisor  = DIV_D_W'(harm_k);
  end

  // Sequencer, phase accumulators and output beat control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ret_state   <= ST_IDLE;
      harm_k      <= '0;
      fund_phase  <= '0;
      harm_phase  <= '0;
      vib_phase   <= '0;
      audio_valid <= 1'b0;
    end else begin
      if (out_load) begin
        audio_valid <= 1'b1;
      end else if (audio.ready) begin
        audio_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (tick.valid) begin
            if (tick.restart) begin
              fund_phase <= '0;
              harm_phase <= '0;
              vib_phase  <= '0;
            end
            state <= ST_START;
          end
        end
        ST_START: begin
          ret_state <= ST_F_AMP;
          state     <= ST_SIN0;
        end
        ST_SIN0:  state <= ST_SIN1;
        ST_SIN1:  state <= ST_SIN2;
        ST_SIN2:  state <= ST_SIN3;
        ST_SIN3:  state <= ret_state;
        ST_F_AMP: state <= ST_F_ACC;
        ST_F_ACC: begin
          harm_k <= HK_W'(1);
          state  <= ST_H_CHECK;
        end
        ST_H_CHECK: begin
          if (harm_go) begin
            ret_state <= ST_H_W;
            state     <= ST_SIN0;
          end else if (vib_enable) begin
            ret_state <= ST_V_MUL;
            state     <= ST_SIN0;
          end else begin
            fund_phase <= fund_phase + {1'b0, freq_step};
            harm_phase <= harm_phase + {1'b0, freq_step};
            state      <= ST_DONE;
          end
        end
        ST_H_W:   state <= ST_H_P;
        ST_H_P:   state <= ST_H_DIV;
        ST_H_DIV: state <= ST_H_WAIT;
        ST_H_WAIT: begin
          if (div_rsp.done) begin
            harm_k <= harm_k + 1'b1;
            state  <= ST_H_CHECK;
          end
        end
        ST_V_MUL: state <= ST_V_ADD;
        ST_V_ADD: begin
          fund_phase <= fund_phase + vib_step;
          harm_phase <= harm_phase + {1'b0, freq_step};
          vib_phase  <= vib_phase + {1'b0, vib_rate_step};
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers: sine operands, harmonic phase and limit, the sum and the sample.
  always_ff @(posedge clk) begin
    case (state)
      ST_START: begin
        {sin_neg, sin_x} <= sine_arg(fund_phase);
      end
      ST_SIN1: begin
        z2 <= prod[28:14];
      end
      ST_F_AMP: begin
        term_neg <= sin_neg;
      end
      ST_F_ACC: begin
        acc      <= term_neg ? ('0 - fund_term) : fund_term;
        harm_ph  <= harm_phase;
        harm_lim <= LIM_W'(freq_step);
      end
      ST_H_CHECK: begin
        if (harm_go) begin
          {sin_neg, sin_x} <= sine_arg(harm_ph);
        end else begin
          {sin_neg, sin_x} <= sine_arg(vib_phase);
        end
      end
      ST_H_W: begin
        mag      <= sin_mag;
        term_neg <= sin_neg;
      end
      ST_H_WAIT: begin
        if (div_rsp.done) begin
          acc      <= term_neg ? (acc - harm_term) : (acc + harm_term);
          harm_ph  <= harm_ph + harm_phase;
          harm_lim <= harm_lim + LIM_W'(freq_step);
        end
      end
      ST_V_MUL: begin
        term_neg <= sin_neg;
      end
      default: ;
    endcase
    if (out_load) begin
      result <= res_sat;
    end
  end

  assign tick.ready   = (state == ST_IDLE);
  assign audio.valid  = audio_valid;
  assign audio.sample = result;

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_H_WAIT)
    else $error("divider finished outside the harmonic wait");

  // A harmonic is only evaluated within the count and below Nyquist.
  a_harm_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_H_W |-> harm_k != '0 && harm_lim[LIM_W-1:31] == '0
      && (HC_W + HK_W)'(harm_k) <= (HC_W + HK_W)'(count_eff))
    else $error("harmonic evaluated outside its allowed range");

  // An accepted tick always starts the fundamental.
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> state == ST_START)
    else $error("accepted tick did not start the sequence");

  // A finished sample waits while the previous one is still held downstream.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && audio.valid && !audio.ready |=> state == ST_DONE)
    else $error("sample overwritten while the output was stalled");

endmodule
